FILE: hw/rtl/ems_pkg.sv
// shared constants for the edge midpoint subdivision block
// no dependencies
package ems_pkg;

    localparam int PosW    = 20;
    localparam int PosN    = 3;
    localparam int VecW    = 16;
    localparam int VecN    = 3;
    localparam int TexW    = 16;
    localparam int TexN    = 2;
    localparam int QBits   = 15;                  // result bits 16384 down to 1
    localparam int Latency = 4 + QBits;           // sum, square, length, search, sign
    localparam int InW     = 376;
    localparam int OutW    = 192;

endpackage

FILE: hw/rtl/ems_norm.sv
// pipelined unit-length scaling of the sum of two Q1.14 vectors
// depends on ems_pkg; every stage advances only under en
module ems_norm
(
    input  logic        clk,
    input  logic        en,
    input  logic [47:0] a,
    input  logic [47:0] b,
    output logic [47:0] mid,
    output logic        degenerate
);
    import ems_pkg::*;

    logic signed [16:0] s_reg [VecN];
    logic [32:0]        sq_reg [VecN];
    logic [VecN-1:0]    neg1_reg;
    logic [33:0]        len_next;

    logic signed [67:0] r_reg [QBits+1][VecN];
    logic [47:0]        p_reg [QBits+1][VecN];
    logic [14:0]        q_reg [QBits+1][VecN];
    logic [33:0]        l_reg [QBits+1];
    logic [VecN-1:0]    neg_reg [QBits+1];
    logic               z_reg [QBits+1];

    logic [47:0]        mid_reg;
    logic               deg_reg;

    // first stage: component sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VecN; i++)
            begin
                s_reg[i] <= 17'($signed(a[i*VecW +: VecW])) + 17'($signed(b[i*VecW +: VecW]));
            end
        end
    end

    // second stage: magnitudes squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VecN; i++)
            begin
                logic [16:0] m;
                m = s_reg[i][16] ? 17'(-s_reg[i]) : 17'(s_reg[i]);
                sq_reg[i]   <= 33'(m) * 33'(m);
                neg1_reg[i] <= s_reg[i][16];
            end
        end
    end

    assign len_next = 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);

    // third stage: squared length and starting residual mag^2*2^30 - L
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VecN; i++)
            begin
                r_reg[0][i] <= $signed({35'd0, sq_reg[i]} << 30) - $signed({34'd0, len_next});
                p_reg[0][i] <= '0;
                q_reg[0][i] <= '0;
            end
            l_reg[0]   <= len_next;
            neg_reg[0] <= neg1_reg;
            z_reg[0]   <= (len_next == '0);
        end
    end

    // one result bit per stage, residual kept against (2q-1)^2 * L
    for (genvar j = 0; j < QBits; j++)
    begin : g_bit
        localparam int K = QBits - 1 - j;
        for (genvar i = 0; i < VecN; i++)
        begin : g_comp
            logic [67:0]        l68;
            logic [67:0]        d;
            logic signed [67:0] cand;
            logic               take;
            assign l68  = {34'd0, l_reg[j]};
            assign d    = ({20'd0, p_reg[j][i]} << (K + 3)) + (l68 << (2*K + 2)) - (l68 << (K + 2));
            assign cand = r_reg[j][i] - $signed(d);
            // once the value reaches 1.0 no lower bit may be added
            assign take = !cand[67] && !((K < QBits - 1) && q_reg[j][i][QBits-1]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j+1][i] <= take ? cand : r_reg[j][i];
                    p_reg[j+1][i] <= take ? p_reg[j][i] + (48'(l_reg[j]) << K) : p_reg[j][i];
                    q_reg[j+1][i] <= take ? (q_reg[j][i] | 15'(1 << K)) : q_reg[j][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                l_reg[j+1]   <= l_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                z_reg[j+1]   <= z_reg[j];
            end
        end
    end

    // last stage: sign and zero-length handling
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VecN; i++)
            begin
                logic [15:0] qv;
                qv = {1'b0, q_reg[QBits][i]};
                if (z_reg[QBits])
                begin
                    mid_reg[i*VecW +: VecW] <= '0;
                end
                else
                begin
                    mid_reg[i*VecW +: VecW] <= neg_reg[QBits][i] ? 16'(-qv) : qv;
                end
            end
            deg_reg <= z_reg[QBits];
        end
    end

    assign mid        = mid_reg;
    assign degenerate = deg_reg;

endmodule

FILE: hw/rtl/edge_midpoint_subdivision.sv
// edge midpoint subdivision: midpoint vertex of one mesh edge per transfer
// depends on ems_pkg and ems_norm
//
// channel  dir  signals                       contents
// s_axis   in   tvalid tready tdata[375:0]    both endpoint vertices
// m_axis   out  tvalid tready tdata[191:0]    midpoint vertex
//                tuser[1:0]                   degenerate flags
//
// one edge per cycle while the output is not stalled; normalising uses a 15-stage bit search
// per normal and tangent component
// reset clears the valid bits only
// a stalled output holds the whole pipeline; nothing is dropped or repeated
module edge_midpoint_subdivision
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // first_position, second_position, first_normal, second_normal,
    // first_tangent, second_tangent, first_texcoord, second_texcoord
    input  logic [ems_pkg::InW-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // mid_position, mid_normal, mid_tangent, mid_texcoord, zero pad
    output logic [ems_pkg::OutW-1:0] m_axis_tdata,
    // normal_degenerate, tangent_degenerate
    output logic [1:0]               m_axis_tuser
);
    import ems_pkg::*;

    logic            en;
    logic [Latency-1:0] valid_reg;
    logic [59:0]     pos_next;
    logic [31:0]     tex_next;
    logic [59:0]     pos_reg [Latency];
    logic [31:0]     tex_reg [Latency];
    logic [47:0]     nrm_mid, tan_mid;
    logic            nrm_deg, tan_deg;

    assign en            = !valid_reg[Latency-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        for (int i = 0; i < PosN; i++)
        begin
            logic [20:0] sa;
            sa = 21'({~s_axis_tdata[i*PosW+19], s_axis_tdata[i*PosW +: 19]})
               + 21'({~s_axis_tdata[60+i*PosW+19], s_axis_tdata[60+i*PosW +: 19]});
            pos_next[i*PosW +: PosW] = {~sa[20], sa[19:1]};
        end
        for (int i = 0; i < TexN; i++)
        begin
            logic [16:0] st;
            st = 17'(s_axis_tdata[312+i*TexW +: TexW]) + 17'(s_axis_tdata[344+i*TexW +: TexW]);
            tex_next[i*TexW +: TexW] = st[16:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[Latency-2:0], s_axis_tvalid};
        end
    end

    // position and texture midpoints ride alongside the normalising pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= pos_next;
            tex_reg[0] <= tex_next;
            for (int i = 1; i < Latency; i++)
            begin
                pos_reg[i] <= pos_reg[i-1];
                tex_reg[i] <= tex_reg[i-1];
            end
        end
    end

    ems_norm u_norm
    (
        .clk        (clk),
        .en         (en),
        .a          (s_axis_tdata[167:120]),
        .b          (s_axis_tdata[215:168]),
        .mid        (nrm_mid),
        .degenerate (nrm_deg)
    );

    ems_norm u_tan
    (
        .clk        (clk),
        .en         (en),
        .a          (s_axis_tdata[263:216]),
        .b          (s_axis_tdata[311:264]),
        .mid        (tan_mid),
        .degenerate (tan_deg)
    );

    assign m_axis_tvalid = valid_reg[Latency-1];
    assign m_axis_tdata  = {4'd0, tex_reg[Latency-1], tan_mid, nrm_mid, pos_reg[Latency-1]};
    assign m_axis_tuser  = {tan_deg, nrm_deg};

endmodule
